// File: src/age_ordered_peer_table_macros.svh
// Assertion macros for the peer table.
`ifndef AGE_ORDERED_PEER_TABLE_MACROS_SVH
`define AGE_ORDERED_PEER_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
`define AOPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AOPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define AOPT_ASSERT(lbl, clk, rst_n, prop, msg)
`define AOPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/aopt_pkg.sv
`default_nettype none
package aopt_pkg;

    localparam int CAPACITY  = 32;
    localparam int ID_W      = 48;
    localparam int META_W    = 32;
    localparam int AGE_W     = 16;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int REQ_W     = 3;
    localparam int STAT_W    = 3;
    localparam int CAP_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [CAP_W-1:0] CAP_RESET    = 6'd32;
    localparam logic [AGE_W-1:0] EXPIRY_RESET = 16'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_CAP_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY_AGE = 1'b1;

    localparam logic [REQ_W-1:0] REQ_ADD      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UPDATE   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_AGE_EXP  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_AGE_ONLY = 3'd4;
    localparam logic [REQ_W-1:0] REQ_READ     = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOMETA   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd5;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [AGE_W-1:0]  age;
        logic [META_W-1:0] meta;
    } entry_t;

    typedef struct packed {
        logic              add;
        logic              del;
        logic              upd;
        logic              age;
        logic              expire;
        logic [META_W-1:0] upd_meta;
    } cell_cmd_t;

endpackage
`default_nettype wire

// File: src/aopt_cell.sv
`default_nettype none
module aopt_cell (
    input  wire logic                      aclk,
    input  wire logic                      capture,
    input  wire logic [aopt_pkg::ID_W-1:0]  probe_id,
    input  wire logic [aopt_pkg::AGE_W-1:0] expiry_age,
    input  wire logic                      valid,
    input  wire logic                      sel,
    input  wire aopt_pkg::cell_cmd_t        cmd,
    input  wire aopt_pkg::entry_t           left_entry,
    input  wire aopt_pkg::entry_t           right_entry,
    input  wire logic                      found_in,
    input  wire logic                      hit_in,
    output aopt_pkg::entry_t                entry,
    output logic                           found_out,
    output logic                           hit_out,
    output logic                           first_hit,
    output aopt_pkg::entry_t                rd_entry
);
    import aopt_pkg::*;

    entry_t entry_reg, entry_next;
    logic   match_reg, age_hit_reg, sel_reg;

    // compare flags are taken when the word is accepted, used in the apply cycle
    always_ff @(posedge aclk) begin
        if (capture) begin
            match_reg   <= valid && (entry_reg.id == probe_id);
            age_hit_reg <= valid && (entry_reg.age == expiry_age);
            sel_reg     <= valid && sel;
        end
        entry_reg <= entry_next;
    end

    assign found_out = found_in | match_reg;
    assign hit_out   = hit_in | age_hit_reg;
    assign first_hit = age_hit_reg & ~hit_in;
    assign entry     = entry_reg;
    assign rd_entry  = sel_reg ? entry_reg : '0;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.add) begin
            entry_next = left_entry;
        end else if (cmd.del && (found_in || match_reg)) begin
            entry_next = right_entry;
        end else if (cmd.upd && match_reg && !found_in) begin
            entry_next.meta = cmd.upd_meta;
        end else if (cmd.age && !(cmd.expire && (hit_in || age_hit_reg))) begin
            if (entry_reg.age != '1) begin
                entry_next.age = entry_reg.age + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: src/age_ordered_peer_table.sv
// Each word passes an accept cycle and an apply cycle; the block takes no new word
// until the apply cycle of the last one is done. The accept cycle latches the per-cell
// compare flags, the apply cycle shifts or updates the cell row and the count.
// The apply cycle waits while the output register holds an untaken result.
// Reset: synchronous active-low aresetn clears the entry count, the handshake
// state and restores capacity_limit to 32 and expiry_age to 5.
`default_nettype none
`include "age_ordered_peer_table_macros.svh"
module age_ordered_peer_table (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [aopt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [aopt_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [aopt_pkg::REQ_W-1:0]     s_req_type,
    input  wire logic [aopt_pkg::ID_W-1:0]      s_peer_id,
    input  wire logic [aopt_pkg::META_W-1:0]    s_meta_value,
    input  wire logic                           s_meta_present,
    input  wire logic [aopt_pkg::IDX_W-1:0]     s_read_index,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [aopt_pkg::STAT_W-1:0]         m_status,
    output logic [aopt_pkg::CNT_W-1:0]          m_entry_count,
    output logic [aopt_pkg::ID_W-1:0]           m_out_peer_id,
    output logic [aopt_pkg::META_W-1:0]         m_out_meta,
    output logic [aopt_pkg::AGE_W-1:0]          m_out_age
);
    import aopt_pkg::*;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CAP_W-1:0]     cap_limit_reg;
    logic [AGE_W-1:0]     expiry_reg;
    logic [REQ_W-1:0]     req_reg;
    logic [ID_W-1:0]      id_reg;
    logic [META_W-1:0]    meta_reg;
    logic                 mp_reg;
    logic                 rd_ok_reg;

    logic                 m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]    status_reg, status_next;
    logic [CNT_W-1:0]     ocount_reg;
    entry_t               rd_out_reg;

    logic                 capture, go;
    logic [CNT_W-1:0]     limit;
    logic                 found_all, hit_all, room;
    logic [CNT_W-1:0]     hit_pos;
    entry_t               new_entry, rd_any;
    cell_cmd_t            cmd;

    entry_t               cell_entry [CAPACITY];
    entry_t               cell_rd    [CAPACITY];
    logic [CAPACITY:0]    found_c, hit_c;
    logic [CAPACITY-1:0]  first_hit;

    assign capture = s_valid && s_ready;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_limit_reg <= CAP_RESET;
            expiry_reg    <= EXPIRY_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CAP_LIMIT:  cap_limit_reg <= cfg_wdata[CAP_W-1:0];
                CFG_EXPIRY_AGE: expiry_reg    <= cfg_wdata[AGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            req_reg   <= s_req_type;
            id_reg    <= s_peer_id;
            meta_reg  <= s_meta_value;
            mp_reg    <= s_meta_present;
            rd_ok_reg <= CNT_W'(s_read_index) < count_reg;
        end
    end

    // cell row
    assign found_c[0] = 1'b0;
    assign hit_c[0]   = 1'b0;
    assign new_entry  = '{id: id_reg, age: AGE_W'(1), meta: (mp_reg ? meta_reg : '0)};

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        entry_t left_e, right_e;
        if (i == 0) begin : g_first
            assign left_e = new_entry;
        end else begin : g_mid
            assign left_e = cell_entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_e = cell_entry[i];
        end else begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        aopt_cell u_cell (
            .aclk        (aclk),
            .capture     (capture),
            .probe_id    (s_peer_id),
            .expiry_age  (expiry_reg),
            .valid       (count_reg > CNT_W'(i)),
            .sel         (s_read_index == IDX_W'(i)),
            .cmd         (cmd),
            .left_entry  (left_e),
            .right_entry (right_e),
            .found_in    (found_c[i]),
            .hit_in      (hit_c[i]),
            .entry       (cell_entry[i]),
            .found_out   (found_c[i+1]),
            .hit_out     (hit_c[i+1]),
            .first_hit   (first_hit[i]),
            .rd_entry    (cell_rd[i])
        );
    end

    assign found_all = found_c[CAPACITY];
    assign hit_all   = hit_c[CAPACITY];
    assign limit     = (cap_limit_reg > CAP_W'(CAPACITY)) ? CNT_W'(CAPACITY)
                                                          : CNT_W'(cap_limit_reg);
    assign room      = count_reg < limit;

    // first_hit is one-hot or zero
    always_comb begin
        hit_pos = '0;
        rd_any  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first_hit[i]) begin
                hit_pos = hit_pos | CNT_W'(i);
            end
            rd_any = rd_any | cell_rd[i];
        end
    end

    always_comb begin
        cmd          = '0;
        cmd.upd_meta = meta_reg;
        cmd.add      = go && (req_reg == REQ_ADD) && !found_all && room;
        cmd.del      = go && (req_reg == REQ_DELETE) && found_all;
        cmd.upd      = go && (req_reg == REQ_UPDATE) && mp_reg;
        cmd.age      = go && ((req_reg == REQ_AGE_EXP) || (req_reg == REQ_AGE_ONLY));
        cmd.expire   = req_reg == REQ_AGE_EXP;
    end

    always_comb begin
        status_next = ST_OK;
        count_next  = count_reg;
        case (req_reg)
            REQ_ADD: begin
                if (found_all) begin
                    status_next = ST_DUP;
                end else if (!room) begin
                    status_next = ST_FULL;
                end else begin
                    count_next = CNT_W'(count_reg + 1'b1);
                end
            end
            REQ_DELETE: begin
                if (found_all) begin
                    count_next = CNT_W'(count_reg - 1'b1);
                end else begin
                    status_next = ST_NOTFOUND;
                end
            end
            REQ_UPDATE: begin
                if (!mp_reg) begin
                    status_next = ST_NOMETA;
                end else if (!found_all) begin
                    status_next = ST_NOTFOUND;
                end
            end
            REQ_AGE_EXP: begin
                if (hit_all) begin
                    count_next = hit_pos;
                end
            end
            REQ_READ: begin
                if (!rd_ok_reg) begin
                    status_next = ST_RANGE;
                end
            end
            default: ;
        endcase
    end

    // handshake control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (go) begin
                count_reg <= count_next;
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        go           = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                s_ready = aresetn;
                if (s_valid) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                if (!m_valid_reg || m_ready) begin
                    go           = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            status_reg <= status_next;
            ocount_reg <= count_next;
            rd_out_reg <= (req_reg == REQ_READ) ? rd_any : '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_entry_count = ocount_reg;
    assign m_out_peer_id = rd_out_reg.id;
    assign m_out_meta    = rd_out_reg.meta;
    assign m_out_age     = rd_out_reg.age;

    `AOPT_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `AOPT_ASSERT_NEXT(a_idle_count, aclk, aresetn, state_reg == S_IDLE, $stable(count_reg), "count moved while idle")
    `AOPT_ASSERT_NEXT(a_dup_count, aclk, aresetn, go && status_next == ST_DUP, count_reg == $past(count_reg), "duplicate add changed count")
    `AOPT_ASSERT_NEXT(a_add_count, aclk, aresetn, cmd.add, count_reg == CNT_W'($past(count_reg) + 1'b1), "add did not grow count")
    `AOPT_ASSERT(a_range_zero, aclk, aresetn, !(m_valid_reg && status_reg == ST_RANGE) || rd_out_reg == '0, "failed read has data")

endmodule
`default_nettype wire

// File: test/tb_age_ordered_peer_table.sv
`timescale 1ns / 1ps

import aopt_pkg::*;

typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [ID_W-1:0]   id;
    logic [META_W-1:0] meta;
    logic              has_meta;
    logic [IDX_W-1:0]  idx;
} peer_request_t;

typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
    logic [ID_W-1:0]   id;
    logic [META_W-1:0] meta;
    logic [AGE_W-1:0]  age;
} peer_reply_t;

// Shadow copy of the table; predicts one reply word per request word.
class peer_table_tracker;
    logic [ID_W-1:0]   ids   [CAPACITY];
    logic [AGE_W-1:0]  ages  [CAPACITY];
    logic [META_W-1:0] metas [CAPACITY];
    int unsigned       count;
    int unsigned       cap_limit;
    logic [AGE_W-1:0]  expiry;
    peer_reply_t       expected_replies[$];
    int unsigned       mismatches;

    function new();
        count      = 0;
        cap_limit  = CAP_RESET;
        expiry     = EXPIRY_RESET;
        mismatches = 0;
    endfunction

    function void set_limits(logic [CAP_W-1:0] cap, logic [AGE_W-1:0] exp_age);
        cap_limit = cap;
        expiry    = exp_age;
    endfunction

    function int lookup(logic [ID_W-1:0] id);
        for (int i = 0; i < int'(count); i++)
            if (ids[i] == id)
                return i;
        return -1;
    endfunction

    // first entry at the expiry age cuts the table there
    function void tick(bit expire);
        for (int i = 0; i < int'(count); i++) begin
            if (expire && ages[i] == expiry) begin
                count = i;
                break;
            end
            if (ages[i] != {AGE_W{1'b1}})
                ages[i]++;
        end
    endfunction

    function void note_request(peer_request_t r);
        peer_reply_t want;
        int          pos;
        int unsigned lim;
        want = '0;
        want.status = ST_OK;
        lim = (cap_limit > CAPACITY) ? CAPACITY : cap_limit;
        case (r.kind)
            REQ_ADD: begin
                if (lookup(r.id) >= 0) begin
                    want.status = ST_DUP;
                end else if (count >= lim) begin
                    want.status = ST_FULL;
                end else begin
                    for (int i = int'(count); i > 0; i--) begin
                        ids[i]   = ids[i-1];
                        ages[i]  = ages[i-1];
                        metas[i] = metas[i-1];
                    end
                    ids[0]   = r.id;
                    ages[0]  = 1;
                    metas[0] = r.has_meta ? r.meta : '0;
                    count++;
                end
            end
            REQ_DELETE: begin
                pos = lookup(r.id);
                if (pos < 0) begin
                    want.status = ST_NOTFOUND;
                end else begin
                    for (int i = pos; i + 1 < int'(count); i++) begin
                        ids[i]   = ids[i+1];
                        ages[i]  = ages[i+1];
                        metas[i] = metas[i+1];
                    end
                    count--;
                end
            end
            REQ_UPDATE: begin
                if (!r.has_meta) begin
                    want.status = ST_NOMETA;
                end else begin
                    pos = lookup(r.id);
                    if (pos < 0)
                        want.status = ST_NOTFOUND;
                    else
                        metas[pos] = r.meta;
                end
            end
            REQ_AGE_EXP:  tick(1'b1);
            REQ_AGE_ONLY: tick(1'b0);
            REQ_READ: begin
                if (r.idx >= count) begin
                    want.status = ST_RANGE;
                end else begin
                    want.id   = ids[r.idx];
                    want.meta = metas[r.idx];
                    want.age  = ages[r.idx];
                end
            end
            default: ;
        endcase
        want.count = CNT_W'(count);
        expected_replies.push_back(want);
    endfunction

    function void check_reply(peer_reply_t got);
        peer_reply_t want;
        if (expected_replies.size() == 0) begin
            $error("reply word with nothing pending: status %0d count %0d",
                   got.status, got.count);
            mismatches++;
            return;
        end
        want = expected_replies.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
        end
        if (got.count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, got.count);
            mismatches++;
        end
        if (got.id !== want.id) begin
            $error("out_peer_id: expected %h, got %h", want.id, got.id);
            mismatches++;
        end
        if (got.meta !== want.meta) begin
            $error("out_meta: expected %h, got %h", want.meta, got.meta);
            mismatches++;
        end
        if (got.age !== want.age) begin
            $error("out_age: expected %0d, got %0d", want.age, got.age);
            mismatches++;
        end
    endfunction
endclass

module tb_age_ordered_peer_table;

    localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int POOL_SIZE       = 48;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [REQ_W-1:0]     s_req_type;
    logic [ID_W-1:0]      s_peer_id;
    logic [META_W-1:0]    s_meta_value;
    logic                 s_meta_present;
    logic [IDX_W-1:0]     s_read_index;
    logic                 m_valid;
    logic                 m_ready;
    logic [STAT_W-1:0]    m_status;
    logic [CNT_W-1:0]     m_entry_count;
    logic [ID_W-1:0]      m_out_peer_id;
    logic [META_W-1:0]    m_out_meta;
    logic [AGE_W-1:0]     m_out_age;

    peer_table_tracker tracker = new();
    logic [ID_W-1:0]   peer_pool [POOL_SIZE];
    int                tx_quiet = 0;
    int                rx_quiet = 0;
    bit                fast_mode = 1'b0;
    bit                hold_off_req = 1'b0;
    int                idle_cycles = 0;

    age_ordered_peer_table dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_peer_id      (s_peer_id),
        .s_meta_value   (s_meta_value),
        .s_meta_present (s_meta_present),
        .s_read_index   (s_read_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_entry_count  (m_entry_count),
        .m_out_peer_id  (m_out_peer_id),
        .m_out_meta     (m_out_meta),
        .m_out_age      (m_out_age)
    );

    always #5 aclk = ~aclk;

    function automatic logic [ID_W-1:0] rand_id();
        return ID_W'({$urandom, $urandom});
    endfunction

    // random idle gap per word, none in fast mode, with occasional runs of back-to-back words
    function automatic int draw_idle(ref int quiet);
        if (fast_mode)
            return 0;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    task automatic issue(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] id,
                         input logic [META_W-1:0] meta, input logic has_meta,
                         input logic [IDX_W-1:0] idx);
        int gap;
        gap = draw_idle(tx_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= kind;
        s_peer_id      <= id;
        s_meta_value   <= meta;
        s_meta_present <= has_meta;
        s_read_index   <= idx;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request('{kind, id, meta, has_meta, idx});
    endtask

    // registers only change with no reply pending
    task automatic configure(input logic [CAP_W-1:0] cap, input logic [AGE_W-1:0] exp_age);
        s_valid <= 1'b0;
        while (tracker.expected_replies.size() != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CAP_LIMIT;
        cfg_wdata <= CFG_W'(cap);
        @(posedge aclk);
        cfg_index <= CFG_EXPIRY_AGE;
        cfg_wdata <= exp_age;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tracker.set_limits(cap, exp_age);
    endtask

    task automatic run_random(input int words, input int add_pct, input bit squeeze);
        int               roll;
        int               top;
        logic [REQ_W-1:0] kind;
        logic [ID_W-1:0]  id;
        logic [IDX_W-1:0] idx;
        for (int n = 0; n < words; n++) begin
            if (squeeze && n == words / 2)
                hold_off_req = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < add_pct) begin
                kind = REQ_ADD;
            end else begin
                roll = (roll - add_pct) * 100 / (100 - add_pct);
                if (roll < 20)      kind = REQ_DELETE;
                else if (roll < 40) kind = REQ_UPDATE;
                else if (roll < 58) kind = REQ_AGE_EXP;
                else if (roll < 70) kind = REQ_AGE_ONLY;
                else if (roll < 96) kind = REQ_READ;
                else if (roll < 98) kind = REQ_RSVD6;
                else                kind = REQ_RSVD7;
            end
            id = ($urandom_range(0, 9) == 0) ? rand_id()
                                              : peer_pool[$urandom_range(0, POOL_SIZE - 1)];
            top = (tracker.count > 31) ? 31 : int'(tracker.count);
            if ($urandom_range(0, 3) == 0)
                idx = IDX_W'($urandom_range(0, 31));
            else
                idx = IDX_W'($urandom_range(0, top));
            issue(kind, id, $urandom, $urandom_range(0, 4) != 0, idx);
        end
    endtask

    // result sink with random back-pressure
    initial begin : result_sink
        int stall;
        stall = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                tracker.check_reply('{m_status, m_entry_count, m_out_peer_id,
                                      m_out_meta, m_out_age});
                stall = draw_idle(rx_quiet);
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        aresetn        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_wdata      <= '0;
        s_valid        <= 1'b0;
        s_req_type     <= '0;
        s_peer_id      <= '0;
        s_meta_value   <= '0;
        s_meta_present <= 1'b0;
        s_read_index   <= '0;
        peer_pool[0] = '0;
        peer_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            peer_pool[i] = rand_id();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limits: capacity 32, expiry at age 5
        issue(REQ_READ,     '0, '0, 1'b0, '0);
        issue(REQ_AGE_EXP,  '0, '0, 1'b0, '0);
        issue(REQ_AGE_ONLY, '0, '0, 1'b0, '0);
        issue(REQ_DELETE,   '0, '0, 1'b0, '0);
        issue(REQ_UPDATE,   '0, '1, 1'b0, '0);
        issue(REQ_UPDATE,   '0, '1, 1'b1, '0);
        issue(REQ_ADD,      '0, '1, 1'b0, '0);     // meta cleared
        issue(REQ_ADD,      '1, '1, 1'b1, '1);
        issue(REQ_ADD,      '1, '0, 1'b1, '0);     // duplicate
        issue(REQ_UPDATE,   '0, 32'h5A5A_A5A5, 1'b1, '0);
        issue(REQ_READ,     '0, '0, 1'b0, 5'd0);
        issue(REQ_READ,     '0, '0, 1'b0, 5'd1);
        issue(REQ_READ,     '1, '1, 1'b1, '1);     // beyond count
        issue(REQ_RSVD6,    rand_id(), $urandom, 1'b1, '1);
        issue(REQ_RSVD7,    rand_id(), $urandom, 1'b0, '0);
        issue(REQ_ADD,      48'h1, 32'h1, 1'b1, '0);
        issue(REQ_DELETE,   '1, '0, 1'b0, '0);     // middle entry
        issue(REQ_AGE_ONLY, '0, '0, 1'b0, '0);
        repeat (4) issue(REQ_AGE_EXP, '0, '0, 1'b0, '0);
        issue(REQ_READ,     '0, '0, 1'b0, 5'd0);
        issue(REQ_READ,     '0, '0, 1'b0, 5'd1);

        configure(6'd0, 16'd0);      // always full, nothing expires
        run_random(20, 50, 1'b0);
        configure(6'd40, 16'd0);     // saturates at capacity
        run_random(90, 75, 1'b1);
        configure(6'd1, 16'd0);      // below the current count
        run_random(30, 50, 1'b0);
        configure(6'd8, 16'd3);
        run_random(100, 40, 1'b1);
        configure(6'd32, 16'd12);
        run_random(100, 45, 1'b0);
        configure(6'd63, 16'd1);
        run_random(50, 40, 1'b0);
        configure(6'd5, 16'd2);
        run_random(60, 45, 1'b0);

        // back-to-back aging run with a high expiry age
        fast_mode = 1'b1;
        configure(6'd32, 16'hFFFF);
        issue(REQ_ADD, peer_pool[2], $urandom, 1'b1, '0);
        repeat (20) issue(REQ_AGE_EXP, '0, '0, 1'b0, '0);
        issue(REQ_READ,     '0, '0, 1'b0, 5'd0);
        issue(REQ_AGE_ONLY, '0, '0, 1'b0, '0);
        issue(REQ_READ,     '0, '0, 1'b0, 5'd0);
        issue(REQ_AGE_EXP,  '0, '0, 1'b0, '0);
        issue(REQ_READ,     '0, '0, 1'b0, 5'd0);
        fast_mode = 1'b0;

        s_valid <= 1'b0;
        while (tracker.expected_replies.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (tracker.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
